FILE: design/icd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icd_pkg
// Shared widths, codes and types of the impact contact detector.
// ----------------------------------------------------------------------------
package icd_pkg;

    // Averaging depth of the two acceleration rings
    localparam int AVG_DEPTH = 3;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int ACC_W    = 16;
    localparam int REFL_W   = 12;
    localparam int IMP_W    = 15;
    localparam int HOLD_W   = 16;
    localparam int MAG_W    = 32;
    localparam int CODE_W   = 2;

    // Derived widths of the averaging path
    localparam int SUM_W    = ACC_W + $clog2(AVG_DEPTH + 1);
    localparam int Q_W      = SUM_W - 1;
    localparam int CNT_W    = $clog2(AVG_DEPTH + 1);
    localparam int IDX_W    = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int ITER_W   = $clog2(Q_W);
    localparam int PROD_W   = 2 * Q_W;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_THR     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLARITY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_HOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTACT_HOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LIMIT   = 3'd5;

    // Register reset values
    localparam logic [REFL_W-1:0] RST_LINE_THR     = 12'd1800;
    localparam logic              RST_POLARITY     = 1'b1;
    localparam logic [IMP_W-1:0]  RST_IMPACT_THR   = 15'd2500;
    localparam logic [HOLD_W-1:0] RST_TURN_HOLD    = 16'd100;
    localparam logic [HOLD_W-1:0] RST_CONTACT_HOLD = 16'd1000;
    localparam logic [HOLD_W-1:0] RST_FULL_LIMIT   = 16'd200;

    // Speed mode codes
    localparam logic [CODE_W-1:0] SPEED_SEARCH    = 2'd0;
    localparam logic [CODE_W-1:0] SPEED_FULL      = 2'd1;
    localparam logic [CODE_W-1:0] SPEED_SUSTAINED = 2'd2;

    // Turn request codes
    localparam logic [CODE_W-1:0] TURN_NONE  = 2'd0;
    localparam logic [CODE_W-1:0] TURN_RIGHT = 2'd1;
    localparam logic [CODE_W-1:0] TURN_LEFT  = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_START_X,
        ST_WAIT_X,
        ST_SQ_X,
        ST_START_Y,
        ST_WAIT_Y,
        ST_SQ_Y,
        ST_SQ_THR,
        ST_CHECK,
        ST_DECIDE,
        ST_DONE
    } t_state;

endpackage : icd_pkg
`default_nettype wire

FILE: design/icd_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icd_divider
// Restoring bit-serial divider: unsigned magnitude over the fill count,
// one quotient bit per cycle, done pulse after the last bit.
// ----------------------------------------------------------------------------
module icd_divider
    import icd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [Q_W-1:0]   i_dividend,
    input  wire logic [CNT_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [Q_W-1:0]        o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [ITER_W-1:0] r_iter;
    logic [CNT_W-1:0]  r_rem;
    logic [Q_W-1:0]    r_quo;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    shifted;
    logic              fits;
    logic [CNT_W:0]    diff;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        shifted = {r_rem, r_quo[Q_W-1]};
        fits    = (shifted >= {1'b0, r_div});
        diff    = shifted - {1'b0, r_div};
    end

    // Control: busy until the last quotient bit is shifted in, then pulse done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_iter <= ITER_W'(Q_W - 1);
            end else if (r_busy) begin
                r_iter <= r_iter - 1'b1;
                if (r_iter == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[Q_W-2:0], fits};
            r_rem <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule : icd_divider
`default_nettype wire

FILE: design/impact_contact_detector_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// impact_contact_detector_core
// Ring-averaged accelerometer contact detection with border turn requests.
// ----------------------------------------------------------------------------
// Sequencing: one result per input transaction; a new transaction is accepted
//   only in idle, after the previous result has entered the output slot; the
//   serial divider runs twice per item and dominates the time per item.
// Reset: synchronous, active low; config registers to defaults, rings, sums
//   and timers to zero, speed mode to search, output slot empty.
module impact_contact_detector_core
    import icd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [TIME_W-1:0]     i_now_ms,
    input  wire logic signed [ACC_W-1:0] i_accel_x,
    input  wire logic signed [ACC_W-1:0] i_accel_y,
    input  wire logic [REFL_W-1:0]     i_left_reflect,
    input  wire logic [REFL_W-1:0]     i_right_reflect,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [CODE_W-1:0]          o_turn_request,
    output logic                       o_contact_event,
    output logic                       o_in_contact,
    output logic [CODE_W-1:0]          o_speed_mode,
    output logic [MAG_W-1:0]           o_magnitude_squared,
    // configuration channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Sequencer
    t_state r_state;
    t_state n_state;

    // Configuration registers
    logic [REFL_W-1:0] r_line_thr;
    logic              r_polarity;
    logic [IMP_W-1:0]  r_impact_thr;
    logic [HOLD_W-1:0] r_turn_hold;
    logic [HOLD_W-1:0] r_contact_hold;
    logic [HOLD_W-1:0] r_full_limit;

    // Captured transaction
    logic [TIME_W-1:0]       r_now;
    logic signed [ACC_W-1:0] r_x;
    logic signed [ACC_W-1:0] r_y;
    logic [REFL_W-1:0]       r_left;
    logic [REFL_W-1:0]       r_right;

    // Averaging state
    logic signed [ACC_W-1:0] r_ring_x [AVG_DEPTH];
    logic signed [ACC_W-1:0] r_ring_y [AVG_DEPTH];
    logic signed [SUM_W-1:0] r_sum_x;
    logic signed [SUM_W-1:0] r_sum_y;
    logic [IDX_W-1:0]        r_ring_idx;
    logic [CNT_W-1:0]        r_fill_count;
    logic signed [ACC_W-1:0] r_prev_x;
    logic signed [ACC_W-1:0] r_prev_y;

    // Timing and mode state
    logic [TIME_W-1:0] r_turn_time;
    logic [TIME_W-1:0] r_contact_time;
    logic [TIME_W-1:0] r_full_start;
    logic [CODE_W-1:0] r_mode;
    logic              r_contact_flag;

    // Intermediate results
    logic [MAG_W-1:0] r_sq_x;
    logic [MAG_W-1:0] r_sq_y;
    logic [MAG_W-1:0] r_thr_sq;
    logic [MAG_W-1:0] r_mag;
    logic             r_mag_hit;
    logic             r_full_expired;
    logic             r_turn_ok;
    logic             r_contact_ok;
    logic             r_left_border;
    logic             r_right_border;

    // Pending result
    logic [CODE_W-1:0] r_res_turn;
    logic              r_res_event;

    // Output slot
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_turn;
    logic              r_out_event;
    logic              r_out_contact;
    logic [CODE_W-1:0] r_out_mode;
    logic [MAG_W-1:0]  r_out_mag;

    // Sequencer outputs
    logic in_ready;
    logic div_start;
    logic div_sel_y;
    logic out_load;

    // Shared divider and multiplier
    logic                div_done;
    logic [Q_W-1:0]      div_quotient;
    logic [Q_W-1:0]      div_dividend;
    logic signed [SUM_W-1:0] div_sum;
    logic [Q_W-1:0]      mul_op;
    logic [PROD_W-1:0]   mul_prod;

    logic in_accept;
    logic out_accept;
    logic sample_changed;
    logic [IDX_W-1:0] idx_next;

    assign in_accept  = i_in_valid && in_ready;
    assign out_accept = r_out_valid && i_out_ready;

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_PUSH;
            ST_PUSH:    n_state = ST_START_X;
            ST_START_X: n_state = ST_WAIT_X;
            ST_WAIT_X:  if (div_done) n_state = ST_SQ_X;
            ST_SQ_X:    n_state = ST_START_Y;
            ST_START_Y: n_state = ST_WAIT_Y;
            ST_WAIT_Y:  if (div_done) n_state = ST_SQ_Y;
            ST_SQ_Y:    n_state = ST_SQ_THR;
            ST_SQ_THR:  n_state = ST_CHECK;
            ST_CHECK:   n_state = ST_DECIDE;
            ST_DECIDE:  n_state = ST_DONE;
            ST_DONE:    if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Drive sequencer control outputs
    always_comb begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        div_sel_y = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE:    in_ready = 1'b1;
            ST_START_X: div_start = 1'b1;
            ST_START_Y: begin
                div_start = 1'b1;
                div_sel_y = 1'b1;
            end
            ST_DONE:    out_load = !r_out_valid || i_out_ready;
            default:    in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider operand: magnitude of the selected sum
    always_comb begin
        div_sum      = div_sel_y ? r_sum_y : r_sum_x;
        div_dividend = div_sum[SUM_W-1] ? Q_W'(-div_sum) : Q_W'(div_sum);
    end

    icd_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (r_fill_count),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    // Shared squaring multiplier; an empty ring averages to zero
    always_comb begin
        if (r_state == ST_SQ_THR) begin
            mul_op = Q_W'(r_impact_thr);
        end else if (r_fill_count == '0) begin
            mul_op = '0;
        end else begin
            mul_op = div_quotient;
        end
        mul_prod = PROD_W'(mul_op) * PROD_W'(mul_op);
    end

    // Ring push helpers
    assign sample_changed = (r_x != r_prev_x) || (r_y != r_prev_y);
    assign idx_next = (r_ring_idx == IDX_W'(AVG_DEPTH - 1)) ? '0 : r_ring_idx + 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_thr     <= RST_LINE_THR;
            r_polarity     <= RST_POLARITY;
            r_impact_thr   <= RST_IMPACT_THR;
            r_turn_hold    <= RST_TURN_HOLD;
            r_contact_hold <= RST_CONTACT_HOLD;
            r_full_limit   <= RST_FULL_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_THR:     r_line_thr     <= i_cfg_data[REFL_W-1:0];
                CFG_POLARITY:     r_polarity     <= i_cfg_data[0];
                CFG_IMPACT_THR:   r_impact_thr   <= i_cfg_data[IMP_W-1:0];
                CFG_TURN_HOLD:    r_turn_hold    <= i_cfg_data;
                CFG_CONTACT_HOLD: r_contact_hold <= i_cfg_data;
                CFG_FULL_LIMIT:   r_full_limit   <= i_cfg_data;
                default:          r_line_thr     <= r_line_thr;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_now   <= i_now_ms;
            r_x     <= i_accel_x;
            r_y     <= i_accel_y;
            r_left  <= i_left_reflect;
            r_right <= i_right_reflect;
        end
    end

    // Averaging and detection state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AVG_DEPTH; i++) begin
                r_ring_x[i] <= '0;
                r_ring_y[i] <= '0;
            end
            r_sum_x        <= '0;
            r_sum_y        <= '0;
            r_ring_idx     <= '0;
            r_fill_count   <= '0;
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_turn_time    <= '0;
            r_contact_time <= '0;
            r_full_start   <= '0;
            r_mode         <= SPEED_SEARCH;
            r_contact_flag <= 1'b0;
        end else begin
            case (r_state)
                // push a changed sample into both rings
                ST_PUSH: begin
                    if (sample_changed) begin
                        r_prev_x <= r_x;
                        r_prev_y <= r_y;
                        r_sum_x  <= r_sum_x - SUM_W'(r_ring_x[r_ring_idx]) + SUM_W'(r_x);
                        r_sum_y  <= r_sum_y - SUM_W'(r_ring_y[r_ring_idx]) + SUM_W'(r_y);
                        r_ring_x[r_ring_idx] <= r_x;
                        r_ring_y[r_ring_idx] <= r_y;
                        r_ring_idx <= idx_next;
                        if (r_fill_count != CNT_W'(AVG_DEPTH)) begin
                            r_fill_count <= r_fill_count + 1'b1;
                        end
                    end
                end
                // turn on a border, else declare contact, else expire full speed
                ST_DECIDE: begin
                    if (r_left_border || r_right_border) begin
                        r_contact_flag <= 1'b0;
                        r_mode         <= SPEED_SEARCH;
                        r_turn_time    <= r_now;
                    end else if (r_mag_hit && r_turn_ok && r_contact_ok) begin
                        r_contact_flag <= 1'b1;
                        r_contact_time <= r_now;
                        r_mode         <= SPEED_FULL;
                        r_full_start   <= r_now;
                    end else if (r_mode == SPEED_FULL && r_full_expired) begin
                        r_mode <= SPEED_SUSTAINED;
                    end
                end
                default: begin
                    r_mode <= r_mode;
                end
            endcase
        end
    end

    // Squares, magnitude and registered checks
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_SQ_X:   r_sq_x   <= mul_prod[MAG_W-1:0];
            ST_SQ_Y:   r_sq_y   <= mul_prod[MAG_W-1:0];
            ST_SQ_THR: begin
                r_thr_sq <= mul_prod[MAG_W-1:0];
                r_mag    <= r_sq_x + r_sq_y;
            end
            ST_CHECK: begin
                r_mag_hit      <= r_mag > r_thr_sq;
                r_full_expired <= (r_now - r_full_start) > TIME_W'(r_full_limit);
                r_turn_ok      <= (r_now - r_turn_time) > TIME_W'(r_turn_hold);
                r_contact_ok   <= (r_now - r_contact_time) > TIME_W'(r_contact_hold);
                r_left_border  <= r_polarity ? (r_left < r_line_thr)
                                             : (r_left > r_line_thr);
                r_right_border <= r_polarity ? (r_right < r_line_thr)
                                             : (r_right > r_line_thr);
            end
            ST_DECIDE: begin
                if (r_left_border) begin
                    r_res_turn <= TURN_RIGHT;
                end else if (r_right_border) begin
                    r_res_turn <= TURN_LEFT;
                end else begin
                    r_res_turn <= TURN_NONE;
                end
                r_res_event <= !(r_left_border || r_right_border)
                               && r_mag_hit && r_turn_ok && r_contact_ok;
            end
            default: begin
                r_mag <= r_mag;
            end
        endcase
    end

    // Output slot: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_accept) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_turn    <= r_res_turn;
            r_out_event   <= r_res_event;
            r_out_contact <= r_contact_flag;
            r_out_mode    <= r_mode;
            r_out_mag     <= r_mag;
        end
    end

    assign o_in_ready          = in_ready;
    assign o_out_valid         = r_out_valid;
    assign o_turn_request      = r_out_turn;
    assign o_contact_event     = r_out_event;
    assign o_in_contact        = r_out_contact;
    assign o_speed_mode        = r_out_mode;
    assign o_magnitude_squared = r_out_mag;

    // Checks on sequencing and result consistency
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !o_in_ready)
        else $error("input accepted again while an item is in progress");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_count <= CNT_W'(AVG_DEPTH))
        else $error("fill count beyond averaging depth");

    a_turn_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_turn_request != TURN_NONE)
            |-> (!o_contact_event && !o_in_contact && o_speed_mode == SPEED_SEARCH))
        else $error("turn result carries contact or non-search mode");

    a_event_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_contact_event) |-> (o_in_contact && o_speed_mode == SPEED_FULL))
        else $error("contact event without contact flag and full speed");

    a_load_only_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_out_valid && !i_out_ready) |=> r_state == ST_DONE)
        else $error("result left the sequencer while the output slot was full");

endmodule : impact_contact_detector_core
`default_nettype wire
